[hw/rtl/rcfe_pkg.sv]
package rcfe_pkg;

	localparam int NUM_CHAN  = 8;
	localparam int CHAN_W    = 11;
	localparam int SCALED_W  = 12;
	localparam int FRAME_LEN = 18;
	localparam int POS_W     = 5;

	localparam logic [7:0]          LEN_BYTE    = 8'h11;
	localparam logic [7:0]          CTRL_BYTE   = 8'h01;
	localparam logic [SCALED_W-1:0] CHAN_OFFSET = 12'd1290;

	// register select, taken from paddr[2]
	localparam logic REG_ADDR_LOW  = 1'b0;
	localparam logic REG_ADDR_HIGH = 1'b1;

	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [SCALED_W-1:0] scaled_t;
	typedef logic [7:0]          byte_t;
	typedef logic [POS_W-1:0]    pos_t;

	typedef struct packed {
		byte_t addr_high;
		byte_t addr_low;
		byte_t frame_count;
		byte_t user_count;
	} hdr_t;

	typedef struct packed {
		logic valid;
		logic load;
	} stage_ctl_t;

endpackage

[hw/rtl/rcfe_lane.sv]
module rcfe_lane
	import rcfe_pkg::*;
(
	input  logic    clk,
	input  logic    en,
	input  chan_t   raw,
	output scaled_t scaled_s1
);

	// v*15 as (v<<4)-v, fits in 15 bits
	logic [CHAN_W+3:0] prod;

	assign prod = {raw, 4'b0000} - {4'b0000, raw};

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s1 <= {1'b0, prod[CHAN_W+3:4]} + CHAN_OFFSET;
		end
	end

endmodule

[hw/rtl/rcfe_merge.sv]
module rcfe_merge
	import rcfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  hdr_t       hdr,
	input  scaled_t    scaled_s1 [NUM_CHAN],
	input  logic       valid_s1,
	output stage_ctl_t ctl,
	output logic       out_valid,
	input  logic       out_ready,
	output byte_t      out_byte,
	output pos_t       out_pos,
	output logic       out_last
);

	byte_t frame_d [FRAME_LEN];
	byte_t frame_q [FRAME_LEN];
	pos_t  pos_q;
	logic  busy_q;
	logic  out_fire;
	logic  last;
	logic  load;

	always_comb begin
		frame_d[0]  = LEN_BYTE;
		frame_d[1]  = hdr.addr_high;
		frame_d[2]  = hdr.addr_low;
		frame_d[3]  = hdr.frame_count;
		frame_d[4]  = hdr.user_count;
		frame_d[5]  = CTRL_BYTE;
		for (int k = 0; k < 4; k++) begin
			frame_d[6 + k]  = scaled_s1[k][7:0];
			frame_d[12 + k] = scaled_s1[4 + k][7:0];
		end
		// packed high nibbles, even channel in the low half
		frame_d[10] = {scaled_s1[1][11:8], scaled_s1[0][11:8]};
		frame_d[11] = {scaled_s1[3][11:8], scaled_s1[2][11:8]};
		frame_d[16] = {scaled_s1[5][11:8], scaled_s1[4][11:8]};
		frame_d[17] = {scaled_s1[7][11:8], scaled_s1[6][11:8]};
	end

	assign last     = (pos_q == pos_t'(FRAME_LEN - 1));
	assign out_fire = busy_q && out_ready;
	assign load     = valid_s1 && (!busy_q || (out_fire && last));

	assign ctl.valid = busy_q;
	assign ctl.load  = load;

	assign out_valid = busy_q;
	assign out_byte  = frame_q[0];
	assign out_pos   = pos_q;
	assign out_last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (out_fire) begin
			if (last) begin
				busy_q <= 1'b0;
				pos_q  <= '0;
			end else begin
				pos_q <= pos_q + pos_t'(1);
			end
		end
	end

	// frame shifts down one byte per item sent
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame_d;
		end else if (out_fire) begin
			for (int k = 0; k < FRAME_LEN - 1; k++) begin
				frame_q[k] <= frame_q[k + 1];
			end
			frame_q[FRAME_LEN-1] <= '0;
		end
	end

endmodule

[hw/rtl/rc_channel_frame_encoder_top.sv]
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       s_tdata: counters and eight raw channels
// m_axis    out  m_tvalid / m_tready       m_tdata: frame byte and position, m_tlast
// apb       in   psel / penable / pready   transmitter id bytes
//
// one item gives 18 output items at one per cycle while m_tready is high; the byte serialiser sets the rate
// the next item is taken while the current frame is still being sent
// from accept, an item passes the lane register and then the frame register before its first byte
// reset clears the id registers, stage valid and serialiser; no clearing pass
// a stalled m_tready holds the current byte and backs up into s_tready
module rc_channel_frame_encoder_top
	import rcfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [7:0] frame_count, [15:8] user_frame_count, [26:16] chan0, [37:27] chan1,
	// [48:38] chan2, [59:49] chan3, [70:60] chan4, [81:71] chan5, [92:82] chan6,
	// [103:93] chan7
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] frame_byte, [12:8] byte_position, [15:13] zero
	output logic [15:0]  m_tdata,
	// frame_end
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	byte_t      addr_low_q;
	byte_t      addr_high_q;
	byte_t      frame_count_s1;
	byte_t      user_count_s1;
	logic       valid_s1;
	logic       take;
	hdr_t       hdr;
	stage_ctl_t ctl;
	chan_t      raw [NUM_CHAN];
	scaled_t    scaled_s1 [NUM_CHAN];
	byte_t      out_byte;
	pos_t       out_pos;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_low_q  <= '0;
			addr_high_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_ADDR_LOW:  addr_low_q  <= pwdata[7:0];
				REG_ADDR_HIGH: addr_high_q <= pwdata[7:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ADDR_LOW:  prdata = {24'd0, addr_low_q};
			REG_ADDR_HIGH: prdata = {24'd0, addr_high_q};
			default:       prdata = '0;
		endcase
	end

	assign s_tready = !valid_s1 || ctl.load;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (ctl.load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_count_s1 <= s_tdata[7:0];
			user_count_s1  <= s_tdata[15:8];
		end
	end

	genvar g;
	generate
		for (g = 0; g < NUM_CHAN; g++) begin : g_lane
			assign raw[g] = s_tdata[16 + g*CHAN_W +: CHAN_W];
			rcfe_lane u_lane (
				.clk       (clk),
				.en        (take),
				.raw       (raw[g]),
				.scaled_s1 (scaled_s1[g])
			);
		end
	endgenerate

	assign hdr.addr_high   = addr_high_q;
	assign hdr.addr_low    = addr_low_q;
	assign hdr.frame_count = frame_count_s1;
	assign hdr.user_count  = user_count_s1;

	rcfe_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr       (hdr),
		.scaled_s1 (scaled_s1),
		.valid_s1  (valid_s1),
		.ctl       (ctl),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.out_pos   (out_pos),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, out_pos, out_byte};

endmodule

[hw/rtl/rcfe_checker.sv]
module rcfe_checker
	import rcfe_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [15:0]  m_tdata,
	input logic         m_tlast
);

	// last item of a frame sits at the final position
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[12:8] == pos_t'(FRAME_LEN - 1))
		else $error("tlast away from final frame position");

	// a frame opens with the length byte
	a_len_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12:8] == 5'd0 |-> m_tdata[7:0] == LEN_BYTE)
		else $error("frame does not open with length byte");

	// inside a frame the position steps by one with no gap
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
		m_tvalid && m_tdata[12:8] == $past(m_tdata[12:8]) + 5'd1)
		else $error("frame position skipped or stream broke mid frame");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output item changed");

endmodule

bind rc_channel_frame_encoder_top rcfe_checker u_rcfe_checker (.*);

[test/rc_channel_frame_encoder_top_test.sv]
module rc_channel_frame_encoder_top_test;
	import rcfe_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 24;

	typedef struct packed {
		chan_t [NUM_CHAN-1:0] chan;
		byte_t                user_count;
		byte_t                frame_count;
	} stick_item_t;

	typedef struct packed {
		byte_t frame_byte;
		pos_t  pos;
		logic  last;
	} frame_out_t;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	// typed rows carry the channel low byte and packed nibble byte, identical on all channels
	typedef struct packed {
		logic        typed;
		byte_t       lo;
		byte_t       nib;
		stick_item_t it;
	} directed_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// [7:0] frame_count, [15:8] user_frame_count, [26:16] chan0 .. [103:93] chan7
	logic [103:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// [7:0] frame_byte, [12:8] byte_position, [15:13] zero
	logic [15:0]  m_tdata;
	logic         m_tlast;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	frame_out_t    frame_bytes_due[$];
	frame_out_t    due_byte;
	directed_row_t directed[$];
	byte_t         id_low = 8'h00;
	byte_t         id_high = 8'h00;
	int            mismatches = 0;
	int            cycle_count = 0;
	bit            calm = 1'b0;
	bit            want_hold = 1'b0;
	bit            hold_done = 1'b0;
	int            hold_left = 0;

	rc_channel_frame_encoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic scaled_t scale_stick(chan_t raw);
		logic [15:0] prod;
		prod = {5'b0, raw} * 16'd15;
		return scaled_t'(prod >> 4) + CHAN_OFFSET;
	endfunction

	function automatic frame_t encode_frame(stick_item_t it, byte_t lo, byte_t hi);
		scaled_t s [NUM_CHAN];
		frame_t  f;
		for (int i = 0; i < NUM_CHAN; i++)
			s[i] = scale_stick(it.chan[i]);
		f[0] = LEN_BYTE;
		f[1] = hi;
		f[2] = lo;
		f[3] = it.frame_count;
		f[4] = it.user_count;
		f[5] = CTRL_BYTE;
		for (int i = 0; i < 4; i++) begin
			f[6 + i]  = s[i][7:0];
			f[12 + i] = s[4 + i][7:0];
		end
		// high nibbles in pairs, even channel in the low half
		for (int i = 0; i < 2; i++) begin
			f[10 + i] = {s[2*i + 1][11:8], s[2*i][11:8]};
			f[16 + i] = {s[5 + 2*i][11:8], s[4 + 2*i][11:8]};
		end
		return f;
	endfunction

	function automatic stick_item_t random_item();
		stick_item_t it;
		it.frame_count = ($urandom_range(99) < 75) ? byte_t'($urandom_range(187))
			: byte_t'($urandom_range(255));
		it.user_count = byte_t'($urandom_range(255));
		for (int i = 0; i < NUM_CHAN; i++) begin
			if ($urandom_range(99) < 15)
				it.chan[i] = $urandom_range(1) ? chan_t'(2047) : chan_t'(0);
			else
				it.chan[i] = chan_t'($urandom_range(2047));
		end
		return it;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	task automatic send_item(stick_item_t it, frame_t f);
		if (!calm && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= it;
		do @(posedge clk); while (!s_tready);
		for (int i = 0; i < FRAME_LEN; i++)
			frame_bytes_due.push_back('{frame_byte: f[i], pos: pos_t'(i),
				last: (i == FRAME_LEN - 1)});
	endtask

	// stop offering and let the frames in flight run out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic sel, byte_t val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= {24'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_ADDR_LOW)
			id_low = val;
		else
			id_high = val;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rc_channel_frame_encoder_top_test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (want_hold && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(99) < 18)
			m_tready <= 1'b0;
		else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_bytes_due.size() == 0)
				report_mismatch("unexpected item", int'(m_tdata), 0);
			else begin
				due_byte = frame_bytes_due.pop_front();
				if (m_tdata[7:0] != due_byte.frame_byte)
					report_mismatch("frame_byte", int'(m_tdata[7:0]),
						int'(due_byte.frame_byte));
				if (m_tdata[12:8] != due_byte.pos)
					report_mismatch("byte_position", int'(m_tdata[12:8]),
						int'(due_byte.pos));
				if (m_tlast != due_byte.last)
					report_mismatch("frame_end", int'(m_tlast), int'(due_byte.last));
			end
		end
	end

	initial begin
		frame_t        f;
		directed_row_t row;
		byte_t         lo_cfg [5];
		byte_t         hi_cfg [5];

		directed.push_back('{typed: 1'b1, lo: 8'h0A, nib: 8'h55,
			it: '{chan: {8{11'd0}}, user_count: 8'h00, frame_count: 8'h00}});
		directed.push_back('{typed: 1'b1, lo: 8'h89, nib: 8'hCC,
			it: '{chan: {8{11'd2047}}, user_count: 8'hFF, frame_count: 8'd187}});
		// frame counter beyond its usual range passes straight through
		directed.push_back('{typed: 1'b1, lo: 8'h89, nib: 8'hCC,
			it: '{chan: {8{11'd2047}}, user_count: 8'h00, frame_count: 8'hFF}});
		directed.push_back('{typed: 1'b1, lo: 8'hCA, nib: 8'h88,
			it: '{chan: {8{11'd1024}}, user_count: 8'h3C, frame_count: 8'd188}});
		directed.push_back('{typed: 1'b0, lo: 8'h00, nib: 8'h00,
			it: '{chan: {4{11'd0, 11'd2047}}, user_count: 8'hFF, frame_count: 8'h00}});
		directed.push_back('{typed: 1'b0, lo: 8'h00, nib: 8'h00,
			it: '{chan: {4{11'd2047, 11'd0}}, user_count: 8'h5A, frame_count: 8'h80}});
		directed.push_back('{typed: 1'b0, lo: 8'h00, nib: 8'h00,
			it: '{chan: {11'd128, 11'd64, 11'd32, 11'd16, 11'd8, 11'd4, 11'd2, 11'd1},
			user_count: 8'h01, frame_count: 8'h01}});
		directed.push_back('{typed: 1'b0, lo: 8'h00, nib: 8'h00,
			it: '{chan: {11'd1024, 11'd512, 11'd256, 11'd1023, 11'h555, 11'h2AA,
			11'd1, 11'd2046}, user_count: 8'hAA, frame_count: 8'h55}});
		directed.push_back('{typed: 1'b0, lo: 8'h00, nib: 8'h00,
			it: '{chan: {8{11'h2AA}}, user_count: 8'h55, frame_count: 8'hAA}});
		directed.push_back('{typed: 1'b0, lo: 8'h00, nib: 8'h00,
			it: '{chan: {8{11'h555}}, user_count: 8'h80, frame_count: 8'd100}});

		lo_cfg = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
		hi_cfg = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
		lo_cfg[3] = byte_t'($urandom_range(255));
		hi_cfg[3] = byte_t'($urandom_range(255));
		lo_cfg[4] = byte_t'($urandom_range(255));
		hi_cfg[4] = byte_t'($urandom_range(255));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// id registers still at their reset value here
		foreach (directed[k]) begin
			row = directed[k];
			if (row.typed) begin
				f = {FRAME_LEN{row.lo}};
				f[10] = row.nib;
				f[11] = row.nib;
				f[16] = row.nib;
				f[17] = row.nib;
				f[0] = LEN_BYTE;
				f[1] = id_high;
				f[2] = id_low;
				f[3] = row.it.frame_count;
				f[4] = row.it.user_count;
				f[5] = CTRL_BYTE;
			end else
				f = encode_frame(row.it, id_low, id_high);
			send_item(row.it, f);
		end

		for (int p = 0; p < 5; p++) begin
			drain();
			write_reg(REG_ADDR_LOW, lo_cfg[p]);
			write_reg(REG_ADDR_HIGH, hi_cfg[p]);
			@(posedge clk);
			want_hold = (p == 1);
			calm = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				row.it = random_item();
				send_item(row.it, encode_frame(row.it, id_low, id_high));
			end
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("rc_channel_frame_encoder_top_test passed");
		else
			$display("rc_channel_frame_encoder_top_test failed");
		$finish;
	end

endmodule
